[design/assert_macros.svh]
// Assertion macros used by the top level of the check-in watchdog.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[design/tcw_pkg.sv]
// Types and constants shared by the check-in watchdog modules.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int FLAG_W      = 16;
  localparam int TIMEOUT_W   = 16;
  localparam int COUNT_W     = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Command codes carried in the cmd field.
  localparam logic [1:0] CMD_CLAIM   = 2'd0;
  localparam logic [1:0] CMD_CHECKIN = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'b1;

  // Register values after reset.
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic                 ENABLE_RESET  = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [FLAG_W-1:0] flag_mask;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [FLAG_W-1:0]  active_flags;
    logic [FLAG_W-1:0]  claimed_flags;
    logic               expired;
    logic [FLAG_W-1:0]  snapshot_flags;
    logic [COUNT_W-1:0] count_value;
  } result_t;

endpackage

[design/tcw_stream_if.sv]
// Valid/ready stream interface carrying one item per handshake.
`timescale 1ns / 1ps

interface tcw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/task_checkin_watchdog.sv]
// Top level of the check-in watchdog: configuration, input register and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A watchdog that is fed only when every registered task has checked in.
// Each item on req is one command: claim flag bits (accepted only when none
// of them is already claimed), check in a task's bits, or one watchdog tick.
// When the checked-in set equals the claimed set the down-counter is reloaded
// if enabled, and the set restarts as the bits of the task that completed it.
// Ticks pass through a divide-by-PRESCALE prescaler; when the counter runs
// out the tick reports expired, saves the checked-in set as a snapshot,
// clears it and reloads. The reload value is timeout_setting * 60 / 16,
// saturated to RELOAD_MAX and kept to 12 bits. Every item gives exactly one
// item on rsp. The block takes one item per clock while rsp is not stalled:
// an item is captured in an input register, then the state update and result
// are formed in one short pass and written to the result register.
// Backpressure on rsp holds the result register and then the input register;
// req.ready drops only when both are full and the result is not being taken.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the
// user must write them only while no item is in flight, as the block does not
// enforce it; a new timeout takes effect at the next reload.
module task_checkin_watchdog #(
  parameter int FLAG_BITS  = 16,
  parameter int PRESCALE   = 16,
  parameter int RELOAD_MAX = 4095
) (
  input  logic                           clk,
  input  logic                           rst,
  tcw_stream_if.sink                     req,
  tcw_stream_if.source                   rsp,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tcw_pkg::*;

  // Configuration registers.
  logic [TIMEOUT_W-1:0] timeout_setting;
  logic                 watchdog_enable;

  // Input register stage.
  logic    s1_valid;
  item_t   s1_item;

  logic    advance;
  logic    [COUNT_W-1:0] reload;
  result_t res;

  // The input stage moves on whenever the result register is empty or its
  // item is being taken in this cycle.
  assign advance   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_setting <= TIMEOUT_RESET;
      watchdog_enable <= ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_setting <= cfg_wdata[TIMEOUT_W-1:0];
        REG_ENABLE:  watchdog_enable <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item <= req.data;
    end
  end

  tcw_reload #(
    .RELOAD_MAX (RELOAD_MAX)
  ) u_reload (
    .timeout (timeout_setting),
    .reload  (reload)
  );

  // The core commits its state on the same edge that loads the result
  // register, so the result always reflects the state after the item.
  tcw_core #(
    .FLAG_BITS  (FLAG_BITS),
    .PRESCALE   (PRESCALE),
    .RELOAD_MAX (RELOAD_MAX)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .enable (watchdog_enable),
    .reload (reload),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.data <= res;
    end
  end

  // An expiry clears the checked-in set.
  `ASSERT_IMPLIES(a_expiry_clears_active, clk, rst, rsp.valid && rsp.data.expired, rsp.data.active_flags == '0)
  // Only ticks expire, and ticks are never reported as accepted.
  `ASSERT_IMPLIES(a_expiry_not_accepted, clk, rst, rsp.valid && rsp.data.expired, !rsp.data.accepted)
  // A held input item stays put until the result register frees up.
  `ASSERT_NEXT(a_input_held, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_item))

endmodule

[design/tcw_reload.sv]
// Reload value: timeout scaled by 60/16, saturated and cut to the counter width.
`timescale 1ns / 1ps

module tcw_reload #(
  parameter int RELOAD_MAX = 4095
) (
  input  logic [tcw_pkg::TIMEOUT_W-1:0] timeout,
  output logic [tcw_pkg::COUNT_W-1:0]   reload
);
  import tcw_pkg::*;

  localparam int ProdW   = TIMEOUT_W + 4;
  localparam int ScaledW = ProdW - 2;

  logic [ProdW-1:0]   prod;
  logic [ScaledW-1:0] scaled;
  logic [ScaledW-1:0] clamped;

  // 60/16 reduces to 15/4: multiply by 15 as a shift and subtract, then drop two bits.
  assign prod    = {timeout, 4'b0000} - {4'b0000, timeout};
  assign scaled  = prod[ProdW-1:2];
  assign clamped = (scaled > ScaledW'(RELOAD_MAX)) ? ScaledW'(RELOAD_MAX) : scaled;
  assign reload  = clamped[COUNT_W-1:0];

endmodule

[design/tcw_core.sv]
// Watchdog state registers and the next-state logic for one item.
`timescale 1ns / 1ps

module tcw_core #(
  parameter int FLAG_BITS  = 16,
  parameter int PRESCALE   = 16,
  parameter int RELOAD_MAX = 4095
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  tcw_pkg::item_t              item,
  input  logic                        enable,
  input  logic [tcw_pkg::COUNT_W-1:0] reload,
  output tcw_pkg::result_t            res
);
  import tcw_pkg::*;

  localparam int EffBits     = (FLAG_BITS < FLAG_W) ? FLAG_BITS : FLAG_W;
  localparam int PsW         = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
  localparam int ResetScaled = int'(TIMEOUT_RESET) * 60 / 16;
  localparam logic [COUNT_W-1:0] ResetCount =
    COUNT_W'((ResetScaled > RELOAD_MAX) ? RELOAD_MAX : ResetScaled);

  logic [EffBits-1:0] claimed, claimed_next;
  logic [EffBits-1:0] active, active_next;
  logic [EffBits-1:0] snapshot, snapshot_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [PsW-1:0]     prescale, prescale_next;

  logic [EffBits-1:0] mask;
  logic [EffBits-1:0] merged;
  logic [PsW:0]       ps_inc;
  logic               ps_wrap;
  logic               accepted;
  logic               expired;

  assign mask    = item.flag_mask[EffBits-1:0];
  assign merged  = active | mask;
  assign ps_inc  = {1'b0, prescale} + (PsW+1)'(1);
  assign ps_wrap = ps_inc >= (PsW+1)'(PRESCALE);

  always_comb begin
    claimed_next  = claimed;
    active_next   = active;
    snapshot_next = snapshot;
    count_next    = count;
    prescale_next = prescale;
    accepted      = 1'b0;
    expired       = 1'b0;
    case (item.cmd)
      CMD_CLAIM: begin
        if ((claimed & mask) == '0) begin
          claimed_next = claimed | mask;
          accepted     = 1'b1;
        end
      end
      CMD_CHECKIN: begin
        // A check-in that completes the claimed set kicks the counter if enabled and
        // starts a new round holding only this task's bits.
        if (merged == claimed) begin
          if (enable) begin
            count_next = reload;
          end
          active_next = mask;
          accepted    = 1'b1;
        end else begin
          active_next = merged;
        end
      end
      CMD_TICK: begin
        if (enable) begin
          if (ps_wrap) begin
            prescale_next = '0;
            if (count <= COUNT_W'(1)) begin
              expired       = 1'b1;
              snapshot_next = active;
              active_next   = '0;
              count_next    = reload;
            end else begin
              count_next = count - COUNT_W'(1);
            end
          end else begin
            prescale_next = ps_inc[PsW-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      claimed  <= '0;
      active   <= '0;
      snapshot <= '0;
      count    <= ResetCount;
      prescale <= '0;
    end else if (step) begin
      claimed  <= claimed_next;
      active   <= active_next;
      snapshot <= snapshot_next;
      count    <= count_next;
      prescale <= prescale_next;
    end
  end

  always_comb begin
    res.accepted       = accepted;
    res.active_flags   = FLAG_W'(active_next);
    res.claimed_flags  = FLAG_W'(claimed_next);
    res.expired        = expired;
    res.snapshot_flags = FLAG_W'(snapshot_next);
    res.count_value    = count_next;
  end

endmodule

[verif/testbench.sv]
// Self-checking testbench of the check-in watchdog: a directed table, then random phases.
`timescale 1ns / 1ps

// The testbench drives command items into the watchdog over the req stream
// and collects one result item per command from the rsp stream. A predictor
// keeps its own copy of the claimed set, the check-in set, the prescaler, the
// down-counter and the expiry snapshot. It runs every accepted command and
// queues the result that the block must produce. Results are compared field
// by field, in order, with the oldest queued entry.
//
// The run has two parts. A short table of directed rows comes first. It
// covers the reset values, claim conflicts, the empty claim, unclaimed
// check-in bits, the unused command, ticks while disabled, an expiry with a
// zero reload value, the saturated reload and a completed check-in while
// disabled. A few rows carry a typed-in result; the rest use the predictor.
// Then come random phases. Each phase first writes both registers while the
// block is idle. Most check-ins use the bit groups of owners whose claims
// succeeded, so the check-in set really completes and kicks the counter.
// Short timeouts let the counter expire often.
module testbench;
  import tcw_pkg::*;

  localparam int         PRESCALE   = 16;
  localparam int         RELOAD_MAX = 4095;
  localparam int         SCALE_MUL  = 60;
  localparam int         SCALE_DIV  = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         GAP_PCT    = 19;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  // One row of the directed table: a register write, or a command that is
  // sent reps times. A typed row carries the exact result it must give.
  typedef struct {
    row_kind_t             kind;
    logic [1:0]            cmd;
    logic [CFG_DATA_W-1:0] value;
    logic [CFG_IDX_W-1:0]  index;
    int                    reps;
    bit                    typed;
    result_t               want;
  } plan_row_t;

  typedef struct {
    bit      typed;
    result_t want;
  } typed_note_t;

  typedef struct {
    logic [TIMEOUT_W-1:0] timeout;
    logic                 enable;
    int                   items;
    bit                   calm;
  } phase_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // While calm is set neither side inserts gaps or stalls.
  bit calm;
  int mismatches;

  tcw_stream_if #(.payload_t(item_t))   cmd_ch ();
  tcw_stream_if #(.payload_t(result_t)) res_ch ();

  task_checkin_watchdog #(
    .FLAG_BITS (FLAG_W),
    .PRESCALE  (PRESCALE),
    .RELOAD_MAX(RELOAD_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (cmd_ch),
    .rsp      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state. The registers follow the writes seen on the config port.
  logic [TIMEOUT_W-1:0] wd_timeout;
  logic                 wd_enable;
  logic [FLAG_W-1:0]    claimed;
  logic [FLAG_W-1:0]    active;
  logic [FLAG_W-1:0]    snapshot;
  logic [COUNT_W-1:0]   counter;
  int unsigned          prescaler;

  result_t     pending_results[$];
  typed_note_t typed_notes[$];
  plan_row_t   plan[$];

  // Stimulus-side view of the claims, used to build well-formed check-ins.
  // It changes only through claims, so it agrees with the predictor.
  logic [FLAG_W-1:0] gen_claimed;
  logic [FLAG_W-1:0] owner_masks[$];

  function automatic logic [COUNT_W-1:0] reload_for(logic [TIMEOUT_W-1:0] t);
    int unsigned r;
    r = (32'(t) * SCALE_MUL) / SCALE_DIV;
    if (r > RELOAD_MAX) begin
      r = RELOAD_MAX;
    end
    return r[COUNT_W-1:0];
  endfunction

  // Applies one command to the predictor state and returns the result the
  // block must give for it.
  function automatic result_t watchdog_step(item_t it);
    result_t           r;
    logic [FLAG_W-1:0] merged;
    r = '0;
    case (it.cmd)
      CMD_CLAIM: begin
        if ((claimed & it.flag_mask) == '0) begin
          claimed    = claimed | it.flag_mask;
          r.accepted = 1'b1;
        end
      end
      CMD_CHECKIN: begin
        // A completed set kicks the counter only while enabled, but the
        // check-in set restarts and the kick is reported either way.
        merged = active | it.flag_mask;
        if (merged == claimed) begin
          if (wd_enable) begin
            counter = reload_for(wd_timeout);
          end
          active     = it.flag_mask;
          r.accepted = 1'b1;
        end else begin
          active = merged;
        end
      end
      CMD_TICK: begin
        if (wd_enable) begin
          prescaler++;
          if (prescaler >= PRESCALE) begin
            prescaler = 0;
            // A wrap with the counter at one or zero is an expiry; the
            // snapshot is taken before the check-in set is cleared.
            if (counter <= 1) begin
              r.expired = 1'b1;
              snapshot  = active;
              active    = '0;
              counter   = reload_for(wd_timeout);
            end else begin
              counter--;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.active_flags   = active;
    r.claimed_flags  = claimed;
    r.snapshot_flags = snapshot;
    r.count_value    = counter;
    return r;
  endfunction

  task automatic report(string line);
    mismatches++;
    $display("%0t: %s", $time, line);
  endtask

  task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      report($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("result 0x%0h arrived with nothing pending", got));
      return;
    end
    want = pending_results.pop_front();
    field_check("accepted", 32'(want.accepted), 32'(got.accepted));
    field_check("active_flags", 32'(want.active_flags), 32'(got.active_flags));
    field_check("claimed_flags", 32'(want.claimed_flags), 32'(got.claimed_flags));
    field_check("expired", 32'(want.expired), 32'(got.expired));
    field_check("snapshot_flags", 32'(want.snapshot_flags), 32'(got.snapshot_flags));
    field_check("count_value", 32'(want.count_value), 32'(got.count_value));
  endtask

  // Everything is sampled at the rising edge, where the inputs driven at the
  // falling edge are stable. Register writes and accepted commands update
  // the predictor in the order in which the block sees them.
  always @(posedge clk) begin : monitor
    typed_note_t note;
    result_t     predicted;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT: wd_timeout = cfg_wdata;
          REG_ENABLE:  wd_enable  = cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        predicted = watchdog_step(cmd_ch.data);
        note      = typed_notes.pop_front();
        pending_results.push_back(note.typed ? note.want : predicted);
      end
      if (res_ch.valid && res_ch.ready) begin
        check_result(res_ch.data);
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The result side stalls at random except during the calm phase.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= calm || ($urandom_range(0, 99) >= GAP_PCT);
    end
  end

  function automatic void add_item(logic [1:0] cmd, logic [FLAG_W-1:0] mask, int reps);
    plan_row_t row;
    row       = '{kind: ROW_ITEM, cmd: cmd, value: mask, index: REG_TIMEOUT,
                  reps: reps, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_typed(logic [1:0] cmd, logic [FLAG_W-1:0] mask, result_t want);
    plan_row_t row;
    row = '{kind: ROW_ITEM, cmd: cmd, value: mask, index: REG_TIMEOUT,
            reps: 1, typed: 1'b1, want: want};
    plan.push_back(row);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{kind: ROW_WRITE, cmd: CMD_CLAIM, value: val, index: idx,
            reps: 0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  // Sends one command and returns at the falling edge after it was taken,
  // with valid still high so that the next command can follow at once.
  task automatic send_item(logic [1:0] cmd, logic [FLAG_W-1:0] mask, bit typed,
                           result_t want);
    typed_note_t note;
    item_t       it;
    note.typed = typed;
    note.want  = want;
    typed_notes.push_back(note);
    if (cmd == CMD_CLAIM && (gen_claimed & mask) == '0) begin
      gen_claimed = gen_claimed | mask;
      if (mask != '0) begin
        owner_masks.push_back(mask);
      end
    end
    while (!calm && $urandom_range(0, 99) < GAP_PCT) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    it.cmd       = cmd;
    it.flag_mask = mask;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= it;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  // Drops valid and waits until every queued result has come back.
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0 || typed_notes.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    phase_t            phases[8];
    int                pick;
    int                sel;
    logic [1:0]        cmd;
    logic [FLAG_W-1:0] mask;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_TIMEOUT;
    cfg_wdata    = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    calm         = 1'b0;
    mismatches   = 0;
    gen_claimed  = '0;

    wd_timeout = TIMEOUT_RESET;
    wd_enable  = ENABLE_RESET;
    claimed    = '0;
    active     = '0;
    snapshot   = '0;
    prescaler  = 0;
    counter    = reload_for(TIMEOUT_RESET);

    // Right after reset the counter holds the reload value of a timeout of
    // 100, and a tick only advances the prescaler; its mask is ignored.
    add_typed(CMD_TICK, 16'hFFFF, result_t'{1'b0, 16'h0, 16'h0, 1'b0, 16'h0, 12'd375});
    // The empty claim is accepted and claims nothing.
    add_typed(CMD_CLAIM, 16'h0000, result_t'{1'b1, 16'h0, 16'h0, 1'b0, 16'h0, 12'd375});
    add_typed(CMD_CLAIM, 16'h000F, result_t'{1'b1, 16'h0, 16'hF, 1'b0, 16'h0, 12'd375});
    // Overlapping claims fail and leave the claimed set alone.
    add_typed(CMD_CLAIM, 16'h0003, result_t'{1'b0, 16'h0, 16'hF, 1'b0, 16'h0, 12'd375});
    add_item(CMD_CLAIM, 16'h00F0, 1);
    add_item(CMD_CLAIM, 16'hFFFF, 1);
    add_item(CMD_UNUSED, 16'hFFFF, 1);
    // A zero timeout gives a zero reload at the next kick.
    add_write(REG_TIMEOUT, 16'd0);
    add_item(CMD_CHECKIN, 16'h000F, 1);
    add_item(CMD_CHECKIN, 16'h00F0, 1);
    // Unclaimed bits block completion until the next expiry.
    add_item(CMD_CHECKIN, 16'hFFFF, 1);
    // Disabled ticks must not move the prescaler.
    add_write(REG_ENABLE, 16'd0);
    add_item(CMD_TICK, 16'h0000, 2);
    add_write(REG_ENABLE, 16'd1);
    // Fifteen more ticks wrap the prescaler with the counter at zero.
    add_item(CMD_TICK, 16'h0000, 15);
    // The largest timeout saturates the reload at its limit.
    add_write(REG_TIMEOUT, 16'hFFFF);
    add_item(CMD_CHECKIN, 16'h00FF, 1);
    // A completed check-in while disabled is reported but does not reload.
    add_write(REG_TIMEOUT, 16'd4);
    add_write(REG_ENABLE, 16'd0);
    add_item(CMD_CHECKIN, 16'h00FF, 1);
    add_write(REG_ENABLE, 16'd1);

    // Short timeouts keep expiries frequent; one phase runs without any
    // gaps or stalls, and one leaves the watchdog disabled.
    phases = '{
      '{16'd1,     1'b1, 90, 1'b0},
      '{16'd0,     1'b1, 80, 1'b0},
      '{16'd4,     1'b1, 80, 1'b0},
      '{16'd2,     1'b0, 40, 1'b0},
      '{16'd0,     1'b1, 80, 1'b1},
      '{16'd1092,  1'b1, 30, 1'b0},
      '{16'hFFFF,  1'b1, 30, 1'b0},
      '{16'd3,     1'b1, 70, 1'b0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].index, plan[i].value);
      end else begin
        repeat (plan[i].reps) begin
          send_item(plan[i].cmd, plan[i].value, plan[i].typed, plan[i].want);
        end
      end
    end

    foreach (phases[p]) begin
      write_reg(REG_TIMEOUT, phases[p].timeout);
      write_reg(REG_ENABLE, 16'(phases[p].enable));
      calm = phases[p].calm;
      for (int n = 0; n < phases[p].items; n++) begin
        pick = $urandom_range(0, 99);
        mask = 16'($urandom);
        if (pick < 8) begin
          // Single-bit, empty or random claims; single-bit ones succeed while free.
          cmd = CMD_CLAIM;
          sel = $urandom_range(0, 4);
          if (sel < 2) begin
            mask = 16'(1) << $urandom_range(0, FLAG_W - 1);
          end else if (sel == 2) begin
            mask = '0;
          end
        end else if (pick < 50) begin
          // Mostly check-ins by real owners; the rest is noise, either any
          // bits or some subset of the claimed bits.
          cmd = CMD_CHECKIN;
          if (owner_masks.size() != 0 && $urandom_range(0, 99) < 85) begin
            mask = owner_masks[$urandom_range(0, owner_masks.size() - 1)];
          end else if ($urandom_range(0, 1) == 1) begin
            mask = mask & gen_claimed;
          end
        end else if (pick < 96) begin
          cmd = CMD_TICK;
        end else begin
          cmd = CMD_UNUSED;
        end
        send_item(cmd, mask, 1'b0, '0);
      end
      calm = 1'b0;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // A hang anywhere ends the run as a failure.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/tcw_pkg.sv
design/tcw_stream_if.sv
design/tcw_reload.sv
design/tcw_core.sv
design/task_checkin_watchdog.sv
verif/testbench.sv
